/* rtl/slt_pkg.sv */
// Shared types and constants for the source lexer token classifier.
// Used by slt_lexer, slt_result_fifo and source_lexer_token_classifier.
package slt_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int RES_DEPTH           = 4;
    localparam int RES_PTR_BITS        = $clog2(RES_DEPTH);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_INT    = 3'd2;
    localparam logic [2:0] MODE_FLOAT  = 3'd3;
    localparam logic [2:0] MODE_STRING = 3'd4;
    localparam logic [2:0] MODE_OPER   = 3'd5;

    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_IF     = 4'd1;
    localparam logic [3:0] KIND_INT    = 4'd2;
    localparam logic [3:0] KIND_FLOAT  = 4'd3;
    localparam logic [3:0] KIND_STRING = 4'd4;
    localparam logic [3:0] KIND_OPER   = 4'd5;
    localparam logic [3:0] KIND_SEMI   = 4'd6;
    localparam logic [3:0] KIND_LPAREN = 4'd7;
    localparam logic [3:0] KIND_RPAREN = 4'd8;
    localparam logic [3:0] KIND_EOF    = 4'd9;
    localparam logic [3:0] KIND_ERROR  = 4'd10;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
    localparam logic [2:0] ERR_WHILE        = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd4;

    // keyword_progress codes: prefixes of "if" and "while"
    localparam logic [3:0] KW_NONE  = 4'd0;
    localparam logic [3:0] KW_I     = 4'd1;
    localparam logic [3:0] KW_IF    = 4'd2;
    localparam logic [3:0] KW_W     = 4'd9;
    localparam logic [3:0] KW_WH    = 4'd10;
    localparam logic [3:0] KW_WHI   = 4'd11;
    localparam logic [3:0] KW_WHIL  = 4'd12;
    localparam logic [3:0] KW_WHILE = 4'd13;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start_offset;
        logic [15:0] end_offset;
        logic [2:0]  code;
        logic        last;
    } token_t;

    typedef struct packed {
        token_t     tok0;
        token_t     tok1;
        logic [1:0] count;
    } result_t;

endpackage

/* rtl/slt_lexer.sv */
// Lexer state and per-byte mode transition; produces up to two tokens per item.
// Depends on slt_pkg.
module slt_lexer #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       char_byte,
    input  logic             end_of_input,
    output slt_pkg::result_t result
);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    logic [2:0]             lex_mode_reg, lex_mode_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] token_start_reg, token_start_next;
    logic                   escape_pending_reg, escape_pending_next;
    logic [3:0]             keyword_progress_reg, keyword_progress_next;
    logic                   error_latched_reg, error_latched_next;

    logic                   fin_valid;
    logic                   fin_err;
    slt_pkg::token_t        fin_tok;
    logic                   a_valid;
    logic                   b_valid;
    slt_pkg::token_t        a_tok;
    slt_pkg::token_t        b_tok;
    logic                   used;
    logic [OFFSET_BITS-1:0] p_inc;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0d]});
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h25, 8'h26, 8'h7c,
                         8'h3c, 8'h3e, 8'h21, 8'h5e, 8'h28, 8'h29, 8'h7e};
    endfunction

    function automatic logic [3:0] kw_advance(input logic [3:0] prog, input logic [7:0] c);
        logic [3:0] r;
        r = slt_pkg::KW_NONE;
        case (prog)
            slt_pkg::KW_I:    if (c == 8'h66) r = slt_pkg::KW_IF;
            slt_pkg::KW_W:    if (c == 8'h68) r = slt_pkg::KW_WH;
            slt_pkg::KW_WH:   if (c == 8'h69) r = slt_pkg::KW_WHI;
            slt_pkg::KW_WHI:  if (c == 8'h6c) r = slt_pkg::KW_WHIL;
            slt_pkg::KW_WHIL: if (c == 8'h65) r = slt_pkg::KW_WHILE;
            default:          r = slt_pkg::KW_NONE;
        endcase
        return r;
    endfunction

    function automatic slt_pkg::token_t mk(input logic [3:0] kind,
                                           input logic [OFFSET_BITS-1:0] s,
                                           input logic [OFFSET_BITS-1:0] e,
                                           input logic [2:0] code);
        slt_pkg::token_t t;
        t.kind         = kind;
        t.start_offset = 16'(s);
        t.end_offset   = 16'(e);
        t.code         = code;
        t.last         = 1'b0;
        return t;
    endfunction

    // pending token closed at the current offset
    always_comb
    begin
        fin_valid = lex_mode_reg != slt_pkg::MODE_IDLE;
        fin_err   = 1'b0;
        fin_tok   = mk(slt_pkg::KIND_IDENT, token_start_reg, byte_offset_reg, slt_pkg::ERR_NONE);
        case (lex_mode_reg)
            slt_pkg::MODE_IDENT:
            begin
                if (keyword_progress_reg == slt_pkg::KW_WHILE)
                begin
                    fin_err = 1'b1;
                    fin_tok = mk(slt_pkg::KIND_ERROR, token_start_reg, byte_offset_reg,
                                 slt_pkg::ERR_WHILE);
                end
                else if (keyword_progress_reg == slt_pkg::KW_IF)
                begin
                    fin_tok = mk(slt_pkg::KIND_IF, token_start_reg, byte_offset_reg,
                                 slt_pkg::ERR_NONE);
                end
            end
            slt_pkg::MODE_INT:
                fin_tok = mk(slt_pkg::KIND_INT, token_start_reg, byte_offset_reg,
                             slt_pkg::ERR_NONE);
            slt_pkg::MODE_FLOAT:
                fin_tok = mk(slt_pkg::KIND_FLOAT, token_start_reg, byte_offset_reg,
                             slt_pkg::ERR_NONE);
            slt_pkg::MODE_OPER:
                fin_tok = mk(slt_pkg::KIND_OPER, token_start_reg, byte_offset_reg,
                             slt_pkg::ERR_NONE);
            slt_pkg::MODE_STRING:
            begin
                fin_err = 1'b1;
                fin_tok = mk(slt_pkg::KIND_ERROR, token_start_reg, byte_offset_reg,
                             slt_pkg::ERR_UNTERMINATED);
            end
            default:
                fin_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        lex_mode_next         = lex_mode_reg;
        byte_offset_next      = byte_offset_reg;
        token_start_next      = token_start_reg;
        escape_pending_next   = escape_pending_reg;
        keyword_progress_next = keyword_progress_reg;
        error_latched_next    = error_latched_reg;
        a_valid = 1'b0;
        b_valid = 1'b0;
        a_tok   = fin_tok;
        b_tok   = fin_tok;
        used    = 1'b0;
        p_inc   = OFFSET_BITS'(byte_offset_reg + 1'b1);

        if (end_of_input)
        begin
            a_valid = fin_valid && !error_latched_reg;
            b_valid = 1'b1;
            b_tok   = mk(slt_pkg::KIND_EOF, byte_offset_reg, byte_offset_reg, slt_pkg::ERR_NONE);
            lex_mode_next         = slt_pkg::MODE_IDLE;
            byte_offset_next      = '0;
            token_start_next      = '0;
            escape_pending_next   = 1'b0;
            keyword_progress_next = slt_pkg::KW_NONE;
            error_latched_next    = 1'b0;
        end
        else if (error_latched_reg)
        begin
            if (byte_offset_reg != OFFSET_MAX)
                byte_offset_next = p_inc;
        end
        else if (byte_offset_reg == OFFSET_MAX)
        begin
            a_valid = 1'b1;
            a_tok   = mk(slt_pkg::KIND_ERROR,
                         fin_valid ? token_start_reg : byte_offset_reg,
                         byte_offset_reg, slt_pkg::ERR_OVERFLOW);
            error_latched_next = 1'b1;
            lex_mode_next      = slt_pkg::MODE_IDLE;
        end
        else
        begin
            byte_offset_next = p_inc;
            case (lex_mode_reg)
                slt_pkg::MODE_IDENT:
                    if (is_alpha(char_byte) || is_digit(char_byte))
                    begin
                        keyword_progress_next = kw_advance(keyword_progress_reg, char_byte);
                        used = 1'b1;
                    end
                slt_pkg::MODE_INT:
                    if (is_digit(char_byte))
                        used = 1'b1;
                    else if (char_byte == 8'h2e)
                    begin
                        lex_mode_next = slt_pkg::MODE_FLOAT;
                        used = 1'b1;
                    end
                slt_pkg::MODE_FLOAT:
                    used = is_digit(char_byte);
                slt_pkg::MODE_OPER:
                    used = is_op(char_byte);
                slt_pkg::MODE_STRING:
                begin
                    used = 1'b1;
                    if (escape_pending_reg)
                        escape_pending_next = 1'b0;
                    else if (char_byte == 8'h5c)
                        escape_pending_next = 1'b1;
                    else if (char_byte == 8'h22)
                    begin
                        a_valid = 1'b1;
                        a_tok   = mk(slt_pkg::KIND_STRING, token_start_reg, p_inc,
                                     slt_pkg::ERR_NONE);
                        lex_mode_next = slt_pkg::MODE_IDLE;
                    end
                end
                default:
                    lex_mode_next = slt_pkg::MODE_IDLE;
            endcase

            if (!used)
            begin
                a_valid       = fin_valid;
                lex_mode_next = slt_pkg::MODE_IDLE;
                if (fin_err)
                begin
                    error_latched_next = 1'b1;
                end
                else
                begin
                    token_start_next = byte_offset_reg;
                    if (is_space(char_byte))
                    begin
                        lex_mode_next = slt_pkg::MODE_IDLE;
                    end
                    else if (is_alpha(char_byte))
                    begin
                        lex_mode_next = slt_pkg::MODE_IDENT;
                        keyword_progress_next = (char_byte == 8'h69) ? slt_pkg::KW_I :
                                                (char_byte == 8'h77) ? slt_pkg::KW_W :
                                                slt_pkg::KW_NONE;
                    end
                    else if (char_byte == 8'h22)
                    begin
                        lex_mode_next       = slt_pkg::MODE_STRING;
                        escape_pending_next = 1'b0;
                    end
                    else if (char_byte == 8'h3b)
                    begin
                        b_valid = 1'b1;
                        b_tok   = mk(slt_pkg::KIND_SEMI, byte_offset_reg, p_inc,
                                     slt_pkg::ERR_NONE);
                    end
                    else if (char_byte == 8'h28)
                    begin
                        b_valid = 1'b1;
                        b_tok   = mk(slt_pkg::KIND_LPAREN, byte_offset_reg, p_inc,
                                     slt_pkg::ERR_NONE);
                    end
                    else if (char_byte == 8'h29)
                    begin
                        b_valid = 1'b1;
                        b_tok   = mk(slt_pkg::KIND_RPAREN, byte_offset_reg, p_inc,
                                     slt_pkg::ERR_NONE);
                    end
                    else if (is_digit(char_byte))
                    begin
                        lex_mode_next = slt_pkg::MODE_INT;
                    end
                    else if (is_op(char_byte))
                    begin
                        lex_mode_next = slt_pkg::MODE_OPER;
                    end
                    else
                    begin
                        b_valid = 1'b1;
                        b_tok   = mk(slt_pkg::KIND_ERROR, byte_offset_reg, p_inc,
                                     slt_pkg::ERR_UNEXPECTED);
                        error_latched_next = 1'b1;
                    end
                end
            end
        end
    end

    // pack into slots, mark the final one
    always_comb
    begin
        result.tok0  = a_valid ? a_tok : b_tok;
        result.tok1  = b_tok;
        result.count = 2'(a_valid) + 2'(b_valid);
        result.tok0.last = !(a_valid && b_valid);
        result.tok1.last = 1'b1;
        if (!fire)
            result.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg         <= slt_pkg::MODE_IDLE;
            byte_offset_reg      <= '0;
            token_start_reg      <= '0;
            escape_pending_reg   <= 1'b0;
            keyword_progress_reg <= slt_pkg::KW_NONE;
            error_latched_reg    <= 1'b0;
        end
        else if (fire)
        begin
            lex_mode_reg         <= lex_mode_next;
            byte_offset_reg      <= byte_offset_next;
            token_start_reg      <= token_start_next;
            escape_pending_reg   <= escape_pending_next;
            keyword_progress_reg <= keyword_progress_next;
            error_latched_reg    <= error_latched_next;
        end
    end

endmodule

/* rtl/slt_result_fifo.sv */
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
// Depends on slt_pkg.
module slt_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slt_pkg::result_t     push,
    input  logic                 pop,
    output slt_pkg::token_t      head,
    output logic                 nonempty,
    output logic                 room2
);

    localparam int PB = slt_pkg::RES_PTR_BITS;

    slt_pkg::token_t mem_reg [slt_pkg::RES_DEPTH];
    logic [PB-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PB:0]     count_reg, count_next;
    logic            do_pop;

    assign nonempty = count_reg != '0;
    assign room2    = count_reg <= (PB+1)'(slt_pkg::RES_DEPTH - 2);
    assign head     = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = PB'(wr_ptr_reg + PB'(push.count));
        rd_ptr_next = PB'(rd_ptr_reg + PB'(do_pop));
        count_next  = (PB+1)'(count_reg + (PB+1)'(push.count) - (PB+1)'(do_pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.tok0;
        if (push.count == 2'd2)
            mem_reg[PB'(wr_ptr_reg + 1'b1)] <= push.tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/source_lexer_token_classifier.sv */
// Streaming lexer: one source byte or end-of-input mark per transfer, tokens out.
// Depends on slt_pkg, slt_lexer and slt_result_fifo.
//
// One item is taken per clock while the result queue has room for two tokens; an item
// is registered on transfer and classified against the lexer state once the queue has
// room for two tokens, and its zero, one or two tokens then enter a four-entry result
// queue, whose head is the output. The output drains one token per cycle while
// out_stall is low, which bounds the sustained rate when items produce two tokens each.
// Offsets are OFFSET_BITS wide internally and reported in their low 16 bits; a byte
// arriving at the largest offset raises an overflow error. After any error, bytes
// produce no tokens until the end-of-input mark, which emits EOF and returns the
// block to its reset state.
module source_lexer_token_classifier #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [15:0] start_offset,
    output logic [15:0] end_offset,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    logic             item_valid_reg, item_valid_next;
    logic [7:0]       char_byte_reg;
    logic             end_of_input_reg;
    logic             room2;
    logic             fire;
    logic             in_xfer;
    slt_pkg::result_t result;
    slt_pkg::token_t  head;

    assign fire     = item_valid_reg && room2;
    assign in_stall = item_valid_reg && !room2;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_xfer)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            char_byte_reg    <= char_byte;
            end_of_input_reg <= end_of_input;
        end
    end

    slt_lexer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .char_byte    (char_byte_reg),
        .end_of_input (end_of_input_reg),
        .result       (result)
    );

    slt_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (result),
        .pop      (!out_stall),
        .head     (head),
        .nonempty (out_valid),
        .room2    (room2)
    );

    assign token_kind   = head.kind;
    assign start_offset = head.start_offset;
    assign end_offset   = head.end_offset;
    assign error_code   = head.code;
    assign last_of_run  = head.last;

endmodule
